### hw/rtl/sscnt_pkg.sv
package sscnt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int COUNT_WIDTH = 16;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int USED_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_ARP = 16'h0806;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [15:0] ARP_REPLY = 16'd2;

    typedef enum logic [2:0] {
        OUT_IGNORED = 3'd0,
        OUT_HIT = 3'd1,
        OUT_INSERT = 3'd2,
        OUT_FULL = 3'd3,
        OUT_ARP = 3'd4
    } outcome_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_SYN = 2'd1,
        KIND_ARP = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic [31:0] addr;
    } work_t;

    localparam int QUEUE_DEPTH = 2;

endpackage

### hw/rtl/syn_source_counter_table.sv
// per-source syn flood counter table
// input: pulse start with the parsed header fields while busy is low; the
//   fields are taken in that cycle (one transfer)
// output: done is high for exactly one cycle with the result fields; the
//   receiver cannot stall, so every result must be captured that cycle
// a front stage classifies each packet and places it in a two-entry queue;
// the back stage walks the source table one slot at a time (scan, then check)
// ignored and arp reply packets report straight from the idle state;
//   a counted syn reports after a serial table scan through the single
//   address memory read port
// throughput: one item per queue pop; busy rises when the queue is full
// reset clears the counters and the slot count; table contents need no
//   clearing since only slots below the slot count are compared
module syn_source_counter_table (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic [15:0] frame_type,
    input  logic [7:0] ip_protocol,
    input  logic [31:0] source_address,
    input  logic syn_flag,
    input  logic ack_flag,
    input  logic [15:0] arp_opcode,
    output logic done,
    output logic [2:0] outcome,
    output logic [7:0] entry_index,
    output logic [15:0] source_syn_count,
    output logic [8:0] distinct_sources,
    output logic [31:0] total_syn_count,
    output logic [31:0] arp_reply_count
);
    import sscnt_pkg::*;

    logic q_valid;
    logic q_pop;
    work_t q_data;

    // classify and queue
    sscnt_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .frame_type(frame_type), .ip_protocol(ip_protocol),
        .source_address(source_address), .syn_flag(syn_flag),
        .ack_flag(ack_flag), .arp_opcode(arp_opcode),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
    );

    // table walk and counters
    sscnt_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data),
        .q_pop(q_pop), .done(done), .outcome(outcome),
        .entry_index(entry_index), .source_syn_count(source_syn_count),
        .distinct_sources(distinct_sources), .total_syn_count(total_syn_count),
        .arp_reply_count(arp_reply_count)
    );

endmodule

### hw/rtl/sscnt_front.sv
module sscnt_front (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic [15:0] frame_type,
    input  logic [7:0] ip_protocol,
    input  logic [31:0] source_address,
    input  logic syn_flag,
    input  logic ack_flag,
    input  logic [15:0] arp_opcode,
    output logic q_valid,
    output sscnt_pkg::work_t q_data,
    input  logic q_pop
);
    import sscnt_pkg::*;

    // two-entry queue between classify and table walk
    work_t q_mem [QUEUE_DEPTH];
    logic rd_ptr_reg, rd_ptr_next;
    logic wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic push;
    work_t cls;

    always_comb
    begin
        cls.addr = source_address;
        if (frame_type == ETH_IPV4 && ip_protocol == PROTO_TCP && syn_flag && !ack_flag)
            cls.kind = KIND_SYN;
        else if (frame_type == ETH_ARP && arp_opcode == ARP_REPLY)
            cls.kind = KIND_ARP;
        else
            cls.kind = KIND_NONE;
    end

    assign busy = (cnt_reg == 2'(QUEUE_DEPTH));
    assign push = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### hw/rtl/sscnt_back.sv
module sscnt_back (
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  sscnt_pkg::work_t q_data,
    output logic q_pop,
    output logic done,
    output logic [2:0] outcome,
    output logic [7:0] entry_index,
    output logic [15:0] source_syn_count,
    output logic [8:0] distinct_sources,
    output logic [31:0] total_syn_count,
    output logic [31:0] arp_reply_count
);
    import sscnt_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_CHECK = 5'b00100,
        ST_CNT   = 5'b01000,
        ST_WRITE = 5'b10000
    } state_t;

    logic [31:0] addr_mem [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] cnt_mem [TABLE_DEPTH];

    state_t state_reg, state_next;
    work_t item_reg;
    logic [USED_W-1:0] used_reg;
    logic [USED_W-1:0] scan_reg;
    logic [31:0] rd_addr_reg;
    logic [COUNT_WIDTH-1:0] rd_cnt_reg;
    logic [COUNT_WIDTH-1:0] new_cnt;
    logic [31:0] syn_tot_reg, arp_tot_reg;
    logic done_reg;
    outcome_t out_reg;
    logic [7:0] idx_reg;
    logic [15:0] cnt_out_reg;
    logic [IDX_W-1:0] scan_idx;
    logic [IDX_W-1:0] hit_idx_reg;

    assign scan_idx = scan_reg[IDX_W-1:0];
    assign q_pop = (state_reg == ST_IDLE) && q_valid;
    assign new_cnt = (rd_cnt_reg == '1) ? rd_cnt_reg : rd_cnt_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_valid && q_data.kind == KIND_SYN) state_next = ST_SCAN;
            ST_SCAN:  state_next = (scan_reg == used_reg) ? ST_WRITE : ST_CHECK;
            ST_CHECK: state_next = (rd_addr_reg == item_reg.addr) ? ST_CNT : ST_SCAN;
            ST_CNT:   state_next = ST_WRITE;
            ST_WRITE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // one table read per slot, registered
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN)
        begin
            rd_addr_reg <= addr_mem[scan_idx];
            rd_cnt_reg <= cnt_mem[scan_idx];
            hit_idx_reg <= scan_idx;
        end
        if (state_reg == ST_CNT)
            cnt_mem[hit_idx_reg] <= new_cnt;
        if (state_reg == ST_WRITE && out_reg == OUT_INSERT)
        begin
            addr_mem[used_reg[IDX_W-1:0]] <= item_reg.addr;
            cnt_mem[used_reg[IDX_W-1:0]] <= COUNT_WIDTH'(1);
        end
        if (q_pop)
            item_reg <= q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg <= '0;
            scan_reg <= '0;
            syn_tot_reg <= '0;
            arp_tot_reg <= '0;
            done_reg <= 1'b0;
            out_reg <= OUT_IGNORED;
            idx_reg <= '0;
            cnt_out_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    scan_reg <= '0;
                    if (q_valid)
                    begin
                        if (q_data.kind == KIND_ARP)
                        begin
                            if (arp_tot_reg != '1)
                                arp_tot_reg <= arp_tot_reg + 1'b1;
                            out_reg <= OUT_ARP;
                            idx_reg <= '0;
                            cnt_out_reg <= '0;
                            done_reg <= 1'b1;
                        end
                        else if (q_data.kind == KIND_NONE)
                        begin
                            out_reg <= OUT_IGNORED;
                            idx_reg <= '0;
                            cnt_out_reg <= '0;
                            done_reg <= 1'b1;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (scan_reg == used_reg)
                    begin
                        if (used_reg == USED_W'(TABLE_DEPTH))
                        begin
                            out_reg <= OUT_FULL;
                            idx_reg <= '0;
                            cnt_out_reg <= '0;
                        end
                        else
                        begin
                            out_reg <= OUT_INSERT;
                            idx_reg <= 8'(used_reg);
                            cnt_out_reg <= 16'(COUNT_WIDTH'(1));
                        end
                    end
                    scan_reg <= scan_reg + 1'b1;
                end
                ST_CHECK: ;
                ST_CNT:
                begin
                    out_reg <= OUT_HIT;
                    idx_reg <= 8'(hit_idx_reg);
                    cnt_out_reg <= 16'(new_cnt);
                end
                ST_WRITE:
                begin
                    if (out_reg == OUT_INSERT)
                        used_reg <= used_reg + 1'b1;
                    if (syn_tot_reg != '1)
                        syn_tot_reg <= syn_tot_reg + 1'b1;
                    done_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign done = done_reg;
    assign outcome = out_reg;
    assign entry_index = idx_reg;
    assign source_syn_count = cnt_out_reg;
    assign distinct_sources = 9'(used_reg);
    assign total_syn_count = syn_tot_reg;
    assign arp_reply_count = arp_tot_reg;

endmodule

### tb/sv/syn_source_counter_table_tb.sv
`timescale 1ns / 100ps

module syn_source_counter_table_tb;

    import sscnt_pkg::*;

    // run limit, far above the slowest correct run (a full table scan on every item)
    localparam int CYCLE_LIMIT = 8000000;
    localparam int RANDOM_ITEMS = 834;
    localparam int POOL_SIZE = 300;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 40;

    typedef struct {
        logic [15:0] etype;
        logic [7:0] proto;
        logic [31:0] addr;
        logic syn;
        logic ack;
        logic [15:0] opcode;
    } packet_t;

    typedef struct {
        outcome_t outc;
        logic [7:0] idx;
        logic [15:0] cnt;
        logic [8:0] used;
        logic [31:0] syn_tot;
        logic [31:0] arp_tot;
    } tally_t;

    typedef struct {
        packet_t pkt;
        bit known;
        tally_t want;
    } vector_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [15:0] frame_type;
    logic [7:0] ip_protocol;
    logic [31:0] source_address;
    logic syn_flag;
    logic ack_flag;
    logic [15:0] arp_opcode;
    logic done;
    logic [2:0] outcome;
    logic [7:0] entry_index;
    logic [15:0] source_syn_count;
    logic [8:0] distinct_sources;
    logic [31:0] total_syn_count;
    logic [31:0] arp_reply_count;

    syn_source_counter_table uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .frame_type(frame_type),
        .ip_protocol(ip_protocol),
        .source_address(source_address),
        .syn_flag(syn_flag),
        .ack_flag(ack_flag),
        .arp_opcode(arp_opcode),
        .done(done),
        .outcome(outcome),
        .entry_index(entry_index),
        .source_syn_count(source_syn_count),
        .distinct_sources(distinct_sources),
        .total_syn_count(total_syn_count),
        .arp_reply_count(arp_reply_count)
    );

    // shadow copy of the source table and counters
    logic [31:0] shadow_addr [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] shadow_cnt [TABLE_DEPTH];
    int shadow_used;
    logic [31:0] shadow_syn;
    logic [31:0] shadow_arp;

    // results still owed by the block, oldest first
    tally_t pending_tallies[$];

    int mismatches;
    int cycle_count;
    int outcome_seen [5];
    int sender_idle_pct;
    logic [31:0] addr_pool [POOL_SIZE];
    int next_new;

    // clock and cycle watchdog
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_tallies.size());
            $display("syn_source_counter_table_tb NOT OK");
            $finish;
        end
    end

    // update the shadow state for one packet and return the result it must give
    function automatic tally_t tally_packet(packet_t p);
        tally_t r;
        int hit_slot;
        r.outc = OUT_IGNORED;
        r.idx = '0;
        r.cnt = '0;
        hit_slot = -1;
        if (p.etype == ETH_IPV4 && p.proto == PROTO_TCP && p.syn && !p.ack)
        begin
            for (int i = 0; i < shadow_used; i++)
                if (hit_slot < 0 && shadow_addr[i] == p.addr)
                    hit_slot = i;
            if (hit_slot >= 0)
            begin
                if (shadow_cnt[hit_slot] != {COUNT_WIDTH{1'b1}})
                    shadow_cnt[hit_slot] = shadow_cnt[hit_slot] + 1'b1;
                r.outc = OUT_HIT;
                r.idx = hit_slot[7:0];
                r.cnt = shadow_cnt[hit_slot];
            end
            else if (shadow_used < TABLE_DEPTH)
            begin
                shadow_addr[shadow_used] = p.addr;
                shadow_cnt[shadow_used] = COUNT_WIDTH'(1);
                r.outc = OUT_INSERT;
                r.idx = shadow_used[7:0];
                r.cnt = 16'd1;
                shadow_used++;
            end
            else
                r.outc = OUT_FULL;
            if (shadow_syn != 32'hFFFF_FFFF)
                shadow_syn = shadow_syn + 1;
        end
        else if (p.etype == ETH_ARP && p.opcode == ARP_REPLY)
        begin
            if (shadow_arp != 32'hFFFF_FFFF)
                shadow_arp = shadow_arp + 1;
            r.outc = OUT_ARP;
        end
        r.used = shadow_used[8:0];
        r.syn_tot = shadow_syn;
        r.arp_tot = shadow_arp;
        return r;
    endfunction

    // present one packet and hold it until the transfer; start stays high afterwards
    task automatic send_packet(packet_t p, bit known, tally_t want);
        tally_t r;
        start <= 1'b1;
        frame_type <= p.etype;
        ip_protocol <= p.proto;
        source_address <= p.addr;
        syn_flag <= p.syn;
        ack_flag <= p.ack;
        arp_opcode <= p.opcode;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = tally_packet(p);
        pending_tallies.push_back(known ? want : r);
    endtask

    // random sender gap before the next packet
    task automatic sender_gap();
        if (sender_idle_pct > 0 && $urandom_range(99, 0) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1))
                @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_tallies.size() != 0)
            @(posedge clk);
    endtask

    function automatic packet_t make_pkt(logic [15:0] et, logic [7:0] pr, logic [31:0] a,
                                         logic s, logic k, logic [15:0] op);
        packet_t p;
        p.etype = et;
        p.proto = pr;
        p.addr = a;
        p.syn = s;
        p.ack = k;
        p.opcode = op;
        return p;
    endfunction

    function automatic vector_t make_row(packet_t p, bit known, outcome_t o, int idx, int cnt,
                                         int used, int syn_tot, int arp_tot);
        vector_t v;
        v.pkt = p;
        v.known = known;
        v.want.outc = o;
        v.want.idx = idx[7:0];
        v.want.cnt = cnt[15:0];
        v.want.used = used[8:0];
        v.want.syn_tot = syn_tot;
        v.want.arp_tot = arp_tot;
        return v;
    endfunction

    // a counted syn, an arp reply, a near miss or a fully random packet; near misses
    // differ from a counted syn in one field, or in both ethertype and opcode
    function automatic packet_t random_packet();
        int pick;
        int slot;
        pick = $urandom_range(99, 0);
        if (pick < 68)
        begin
            if (next_new < POOL_SIZE && $urandom_range(1, 0) == 1)
            begin
                slot = next_new;
                next_new++;
            end
            else
                slot = $urandom_range(next_new > 0 ? next_new - 1 : 0, 0);
            return make_pkt(ETH_IPV4, PROTO_TCP, addr_pool[slot], 1'b1, 1'b0,
                            16'($urandom()));
        end
        else if (pick < 78)
            return make_pkt(ETH_ARP, 8'($urandom()), $urandom(), 1'($urandom()),
                            1'($urandom()), ARP_REPLY);
        else if (pick < 90)
        begin
            packet_t p;
            p = make_pkt(ETH_IPV4, PROTO_TCP, addr_pool[$urandom_range(POOL_SIZE - 1, 0)],
                         1'b1, 1'b0, 16'($urandom()));
            case ($urandom_range(4, 0))
                0: p.etype = ETH_ARP;
                1: p.proto = 8'($urandom_range(255, 7));
                2: p.syn = 1'b0;
                3: p.ack = 1'b1;
                default:
                begin
                    p.etype = ETH_ARP;
                    p.opcode = 16'($urandom_range(1, 0));
                end
            endcase
            return p;
        end
        else
            return make_pkt(16'($urandom()), 8'($urandom()), $urandom(), 1'($urandom()),
                            1'($urandom()), 16'($urandom()));
    endfunction

    // result checker: every done pulse is compared with the oldest expectation
    always @(posedge clk)
    begin
        tally_t w;
        if (rst_n && done)
        begin
            if (outcome < 5)
                outcome_seen[outcome]++;
            if (pending_tallies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: outcome %0d index %0d", outcome, entry_index);
            end
            else
            begin
                w = pending_tallies.pop_front();
                if (outcome !== w.outc || entry_index !== w.idx || source_syn_count !== w.cnt
                    || distinct_sources !== w.used || total_syn_count !== w.syn_tot
                    || arp_reply_count !== w.arp_tot)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at cycle %0d", cycle_count);
                        $display("  expected outcome %0d index %0d count %0d used %0d syn %0d arp %0d",
                                 w.outc, w.idx, w.cnt, w.used, w.syn_tot, w.arp_tot);
                        $display("  actual   outcome %0d index %0d count %0d used %0d syn %0d arp %0d",
                                 outcome, entry_index, source_syn_count, distinct_sources,
                                 total_syn_count, arp_reply_count);
                    end
                end
            end
        end
    end

    initial
    begin
        vector_t directed[$];
        tally_t none;
        int seg;

        start = 1'b0;
        frame_type = '0;
        ip_protocol = '0;
        source_address = '0;
        syn_flag = 1'b0;
        ack_flag = 1'b0;
        arp_opcode = '0;
        rst_n = 1'b0;
        cycle_count = 0;
        mismatches = 0;
        shadow_used = 0;
        shadow_syn = '0;
        shadow_arp = '0;
        next_new = 0;
        sender_idle_pct = 0;
        none = '{OUT_IGNORED, 8'd0, 16'd0, 9'd0, 32'd0, 32'd0};
        for (int i = 0; i < 5; i++)
            outcome_seen[i] = 0;
        for (int i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = $urandom();

        // directed rows: expectations typed in from reset state, last from shadow
        directed.push_back(make_row(make_pkt(16'h0000, 8'h00, 32'h0, 1'b0, 1'b0, 16'h0),
                                    1, OUT_IGNORED, 0, 0, 0, 0, 0));
        directed.push_back(make_row(make_pkt(ETH_ARP, 8'h00, 32'h0, 1'b0, 1'b0, ARP_REPLY),
                                    1, OUT_ARP, 0, 0, 0, 0, 1));
        // arp request and an odd opcode are not counted
        directed.push_back(make_row(make_pkt(ETH_ARP, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'd1),
                                    1, OUT_IGNORED, 0, 0, 0, 0, 1));
        directed.push_back(make_row(make_pkt(ETH_ARP, PROTO_TCP, 32'h0, 1'b1, 1'b0, 16'hFFFF),
                                    1, OUT_IGNORED, 0, 0, 0, 0, 1));
        // first source goes into slot zero, then hits it
        directed.push_back(make_row(make_pkt(ETH_IPV4, PROTO_TCP, 32'h0, 1'b1, 1'b0, 16'h0),
                                    1, OUT_INSERT, 0, 1, 1, 1, 1));
        directed.push_back(make_row(make_pkt(ETH_IPV4, PROTO_TCP, 32'h0, 1'b1, 1'b0, 16'hFFFF),
                                    1, OUT_HIT, 0, 2, 1, 2, 1));
        directed.push_back(make_row(make_pkt(ETH_IPV4, PROTO_TCP, 32'hFFFF_FFFF, 1'b1, 1'b0,
                                             ARP_REPLY), 1, OUT_INSERT, 1, 1, 2, 3, 1));
        // syn-ack, bare ack, plain packet, udp, all-ones ethertype and protocol: ignored
        directed.push_back(make_row(make_pkt(ETH_IPV4, PROTO_TCP, 32'h0, 1'b1, 1'b1, 16'h0),
                                    1, OUT_IGNORED, 0, 0, 2, 3, 1));
        directed.push_back(make_row(make_pkt(ETH_IPV4, PROTO_TCP, 32'h0, 1'b0, 1'b1, 16'h0),
                                    1, OUT_IGNORED, 0, 0, 2, 3, 1));
        directed.push_back(make_row(make_pkt(ETH_IPV4, PROTO_TCP, 32'h0, 1'b0, 1'b0, 16'h0),
                                    1, OUT_IGNORED, 0, 0, 2, 3, 1));
        directed.push_back(make_row(make_pkt(ETH_IPV4, 8'd17, 32'h0, 1'b1, 1'b0, 16'h0),
                                    1, OUT_IGNORED, 0, 0, 2, 3, 1));
        directed.push_back(make_row(make_pkt(16'hFFFF, 8'hFF, 32'h0, 1'b1, 1'b0, ARP_REPLY),
                                    1, OUT_IGNORED, 0, 0, 2, 3, 1));
        // arp ethertype wins over tcp syn fields
        directed.push_back(make_row(make_pkt(ETH_ARP, PROTO_TCP, 32'h0, 1'b1, 1'b0, ARP_REPLY),
                                    1, OUT_ARP, 0, 0, 2, 3, 2));
        directed.push_back(make_row(make_pkt(ETH_IPV4, 8'd0, 32'h0, 1'b0, 1'b0, ARP_REPLY),
                                    1, OUT_IGNORED, 0, 0, 2, 3, 2));
        directed.push_back(make_row(make_pkt(ETH_IPV4, PROTO_TCP, 32'h1234_5678, 1'b1, 1'b0,
                                             16'h0), 1, OUT_INSERT, 2, 1, 3, 4, 2));
        directed.push_back(make_row(make_pkt(ETH_IPV4, PROTO_TCP, 32'hFFFF_FFFF, 1'b1, 1'b0,
                                             16'h0), 1, OUT_HIT, 1, 2, 3, 5, 2));
        directed.push_back(make_row(make_pkt(ETH_IPV4, PROTO_TCP, 32'h1234_5678, 1'b1, 1'b0,
                                             16'h0), 0, OUT_IGNORED, 0, 0, 0, 0, 0));

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, back to back
        foreach (directed[i])
            send_packet(directed[i].pkt, directed[i].known, directed[i].want);

        // pause until every result is back
        wait_drained();
        repeat (8)
            @(posedge clk);

        // random traffic in three segments: light gaps, heavy gaps, none
        for (seg = 0; seg < 3; seg++)
        begin
            sender_idle_pct = (seg == 0) ? 23 : (seg == 1) ? 61 : 0;
            for (int i = 0; i < RANDOM_ITEMS / 3; i++)
            begin
                sender_gap();
                send_packet(random_packet(), 0, none);
            end
            if (seg == 1)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("covered %0d ignored, %0d hits, %0d inserts, %0d table-full drops, %0d arp replies",
                 outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
                 outcome_seen[4]);
        $display("final table use %0d slots, %0d mismatches", shadow_used, mismatches);
        if (mismatches == 0 && pending_tallies.size() == 0)
            $display("syn_source_counter_table_tb OK");
        else
            $display("syn_source_counter_table_tb NOT OK");
        $finish;
    end

endmodule
